@@ hdl/sgm_pkg.sv @@
`default_nettype none

package sgm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 19;
  localparam int unsigned MAG_W    = 22;
  localparam int unsigned ACC_W    = 46;
  localparam int unsigned TAP_W    = 52;
  localparam int unsigned RAD_W    = 62;
  localparam int unsigned ROOT_W   = 31;

  localparam logic signed [TAP_W-1:0] ACC_LIM = TAP_W'(64'sd35184372088831);
  localparam logic [MAG_W-1:0]        MAG_MAX = {MAG_W{1'b1}};

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic tap_mul;
    logic tap_acc;
    logic mag1;
    logic mag2;
    logic mag3;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic root_done;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/sgm_sample_if.sv @@
`default_nettype none

interface sgm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [sgm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ hdl/sgm_mag_if.sv @@
`default_nettype none

interface sgm_mag_if;
  logic                         valid;
  logic                         ready;
  logic [sgm_pkg::MAG_W-1:0]    magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink (input valid, input magnitude, output ready);
endinterface

`default_nettype wire

@@ hdl/sliding_goertzel_magnitude.sv @@
`default_nettype none

// Single-bin Goertzel magnitude over a sliding window of the last TAPS samples.
// Each accepted sample overwrites the oldest window entry, then the recursion
// runs over the window oldest first, each tap passing through the split
// coefficient multiply (S_MUL) and then the accumulate and saturate (S_ACC),
// followed by the radicand products (S_MAG1, S_MAG2, S_MAG3) and a 31-step
// bit-serial square root. No new sample is taken until the result is loaded
// into the output, and a still pending result holds the output load back.
// After reset the window is zero-filled in S_CLEAR, during which no sample is
// taken. A finished magnitude waits in an output register, so the next sample
// can enter while it is pending. The coefficient is signed Q2.16. The user must
// write it only while the block is idle; the block itself does not enforce this.
module sliding_goertzel_magnitude #(
  parameter int unsigned TAPS = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  sgm_sample_if.sink                                sample_chan,
  sgm_mag_if.source                                 result_chan,
  input  wire logic                                 cfg_we_i,
  input  wire logic signed [sgm_pkg::COEF_W-1:0]    bin_coefficient_i
);

  sgm_pkg::cmd_t cmd;
  sgm_pkg::sts_t sts;

  sgm_ctrl #(
    .TAPS(TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_chan.valid),
    .in_ready_o (sample_chan.ready),
    .out_valid_o(result_chan.valid),
    .out_ready_i(result_chan.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sgm_datapath #(
    .TAPS(TAPS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (sample_chan.sample),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (bin_coefficient_i),
    .magnitude_o(result_chan.magnitude)
  );

  a_cmd_exclusive: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd)
  ) else $error("more than one datapath command");

  a_busy_after_request: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    sample_chan.valid && sample_chan.ready |=> !sample_chan.ready
  ) else $error("request taken while a computation is running");

  a_result_from_load: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(result_chan.valid) |-> $past(cmd.load_out)
  ) else $error("result valid without an output load");

endmodule

`default_nettype wire

@@ hdl/sgm_ram.sv @@
`default_nettype none

module sgm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/sgm_isqrt.sv @@
`default_nettype none

module sgm_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sgm_pkg::RAD_W-1:0]   rad_i,
  output logic                             done_o,
  output logic      [sgm_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned RW = sgm_pkg::ROOT_W;
  localparam int unsigned CW = $clog2(RW);

  logic [sgm_pkg::RAD_W-1:0] rad_q;
  logic [RW+1:0]             rem_q;
  logic [RW-1:0]             root_q;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [RW+3:0] rem_sh;
  logic [RW+3:0] trial;
  logic          fits;

  assign rem_sh = {rem_q, rad_q[sgm_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[sgm_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= fits ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ hdl/sgm_ctrl.sv @@
`default_nettype none

module sgm_ctrl #(
  parameter int unsigned TAPS = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sgm_pkg::cmd_t      cmd_o,
  input  wire sgm_pkg::sts_t sts_i
);

  localparam int unsigned AW = $clog2(TAPS);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_ACC   = 9'b000001000,
    S_MAG1  = 9'b000010000,
    S_MAG2  = 9'b000100000,
    S_MAG3  = 9'b001000000,
    S_ROOT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          oval_q, oval_d;
  logic          last;

  assign last = cnt_q == AW'(TAPS - 1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        cnt_d = last ? '0 : cnt_q + 1'b1;
        if (last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.tap_mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.tap_acc = 1'b1;
        cnt_d = last ? '0 : cnt_q + 1'b1;
        state_d = last ? S_MAG1 : S_MUL;
      end
      S_MAG1: begin
        cmd_o.mag1 = 1'b1;
        state_d = S_MAG2;
      end
      S_MAG2: begin
        cmd_o.mag2 = 1'b1;
        state_d = S_MAG3;
      end
      S_MAG3: begin
        cmd_o.mag3 = 1'b1;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (sts_i.root_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          oval_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = oval_q;

endmodule

`default_nettype wire

@@ hdl/sgm_datapath.sv @@
`default_nettype none

module sgm_datapath #(
  parameter int unsigned TAPS = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sgm_pkg::cmd_t                       cmd_i,
  output sgm_pkg::sts_t                            sts_o,
  input  wire logic signed [sgm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                cfg_we_i,
  input  wire logic signed [sgm_pkg::COEF_W-1:0]   cfg_data_i,
  output logic             [sgm_pkg::MAG_W-1:0]    magnitude_o
);

  localparam int unsigned AW = $clog2(TAPS);
  localparam int unsigned SW = sgm_pkg::SAMPLE_W;
  localparam int unsigned TW = sgm_pkg::TAP_W;

  logic signed [sgm_pkg::COEF_W-1:0] coef_q;
  logic [AW-1:0]                     wp_q, rp_q;
  logic [AW-1:0]                     wp_inc, rp_inc;
  logic signed [sgm_pkg::ACC_W-1:0]  s1_q, s2_q;
  logic signed [59:0]                p0_q, sq1_q;
  logic signed [62:0]                p1_q;
  logic [sgm_pkg::MAG_W-1:0]         mag_q;

  logic [SW-1:0]      x_raw;
  logic signed [29:0] m0a, m0b, m1b;
  logic signed [32:0] m1a;
  logic signed [59:0] m0p;
  logic signed [62:0] m1p;
  logic signed [29:0] a1, a2;
  logic signed [65:0] prod;
  logic signed [49:0] prod_sh;
  logic signed [TW-1:0] t_w;
  logic signed [sgm_pkg::ACC_W-1:0] t_sat;
  logic signed [63:0] rad_w;
  logic [sgm_pkg::RAD_W-1:0] rad_clamp;
  logic                       root_done;
  logic [sgm_pkg::ROOT_W-1:0] root;

  assign wp_inc = (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == AW'(TAPS - 1)) ? '0 : rp_q + 1'b1;

  sgm_ram #(
    .WIDTH(SW),
    .DEPTH(TAPS)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (cmd_i.clear_wr || cmd_i.accept),
    .waddr_i(wp_q),
    .wdata_i(cmd_i.accept ? sample_i : '0),
    .raddr_i(rp_q),
    .rdata_o(x_raw)
  );

  assign a1 = $signed(s1_q[45:16]);
  assign a2 = $signed(s2_q[45:16]);

  // operand selection for the two shared multipliers
  always_comb begin
    m0a = '0;
    m0b = '0;
    m1a = '0;
    m1b = '0;
    priority if (cmd_i.tap_mul) begin
      m0a = 30'(coef_q);
      m0b = $signed({7'b0, s1_q[22:0]});
      m1a = 33'(coef_q);
      m1b = 30'($signed(s1_q[45:23]));
    end else if (cmd_i.mag1) begin
      m0a = a1;
      m0b = a1;
      m1a = 33'(coef_q);
      m1b = a1;
    end else if (cmd_i.mag2) begin
      m0a = a2;
      m0b = a2;
      m1a = $signed(p1_q[48:16]);
      m1b = a2;
    end
  end

  assign m0p = m0a * m0b;
  assign m1p = m1a * m1b;

  // c*s1 rebuilt from the two partial products, then floor shift
  assign prod    = $signed({p1_q[42:0], 23'b0}) + 66'(p0_q);
  assign prod_sh = prod[65:16];
  assign t_w     = TW'(prod_sh) - TW'(s2_q) + TW'($signed({x_raw, 16'h0000}));

  always_comb begin
    priority if (t_w > sgm_pkg::ACC_LIM) begin
      t_sat = sgm_pkg::ACC_LIM[sgm_pkg::ACC_W-1:0];
    end else if (t_w < -sgm_pkg::ACC_LIM) begin
      t_sat = sgm_pkg::ACC_W'(-sgm_pkg::ACC_LIM);
    end else begin
      t_sat = t_w[sgm_pkg::ACC_W-1:0];
    end
  end

  assign rad_w     = 64'(sq1_q) + 64'(p0_q) - 64'(p1_q);
  assign rad_clamp = rad_w[63] ? '0 : rad_w[sgm_pkg::RAD_W-1:0];

  sgm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mag3),
    .rad_i  (rad_clamp),
    .done_o (root_done),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      wp_q   <= '0;
      rp_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        coef_q <= cfg_data_i;
      end
      if (cmd_i.clear_wr || cmd_i.accept) begin
        wp_q <= wp_inc;
      end
      if (cmd_i.accept) begin
        rp_q <= wp_inc;
      end else if (cmd_i.tap_mul) begin
        rp_q <= rp_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (cmd_i.tap_acc) begin
      s1_q <= t_sat;
      s2_q <= s1_q;
    end
    if (cmd_i.tap_mul || cmd_i.mag1 || cmd_i.mag2) begin
      p0_q <= m0p;
      p1_q <= m1p;
    end
    if (cmd_i.mag2) begin
      sq1_q <= p0_q;
    end
    if (cmd_i.load_out) begin
      mag_q <= (root > sgm_pkg::ROOT_W'(sgm_pkg::MAG_MAX)) ? sgm_pkg::MAG_MAX
                                                          : root[sgm_pkg::MAG_W-1:0];
    end
  end

  assign sts_o.root_done = root_done;
  assign magnitude_o     = mag_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = sgm_pkg::SAMPLE_W;
  localparam int COEF_W = sgm_pkg::COEF_W;
  localparam int MAG_W = sgm_pkg::MAG_W;
  localparam logic [MAG_W-1:0] MAG_MAX = sgm_pkg::MAG_MAX;

  localparam int TAPS = 64;
  localparam int FRAC = 16;
  localparam longint ACC_SAT = (longint'(1) <<< 45) - 1;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int CALM_FIRST = 700;
  localparam int CALM_LAST = 950;
  localparam real TWO_PI = 6.283185307179586;

  typedef enum logic {ROW_SAMPLE, ROW_COEF} row_kind_e;
  typedef enum logic [1:0] {MODE_NOISE, MODE_EXTREME, MODE_TONE, MODE_QUIET} stim_mode_e;

  typedef struct packed {
    row_kind_e        kind;
    int               value;
    logic             typed;
    logic [MAG_W-1:0] want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic signed [COEF_W-1:0] bin_coefficient_i = '0;

  sgm_sample_if sample_bus ();
  sgm_mag_if    mag_bus ();

  sliding_goertzel_magnitude #(
    .TAPS(TAPS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_chan       (sample_bus),
    .result_chan       (mag_bus),
    .cfg_we_i          (cfg_we_i),
    .bin_coefficient_i (bin_coefficient_i)
  );

  logic signed [SAMPLE_W-1:0] window_q [TAPS];
  int                         wr_pos_q;
  logic signed [COEF_W-1:0]   coef_q;
  logic [MAG_W-1:0]           expected_mags [$];
  logic [MAG_W-1:0]           mag_want;
  bit                         failed = 1'b0;
  bit                         calm = 1'b0;
  int                         stall_left = 0;
  stim_row_t                  directed_rows [24];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #100ms;
    $display("FAIL sliding_goertzel_magnitude");
    $finish;
  end

  // slide the window by one sample and compute the bin magnitude over it
  function automatic logic [MAG_W-1:0] slide_and_measure(input logic signed [SAMPLE_W-1:0] x);
    longint acc1, acc2, nxt, c, a1, a2, cs, rad, root, trial;
    int p;
    window_q[wr_pos_q] = x;
    wr_pos_q = (wr_pos_q + 1) % TAPS;
    p = wr_pos_q;
    acc1 = 0;
    acc2 = 0;
    c = longint'(coef_q);
    for (int i = 0; i < TAPS; i++) begin
      nxt = ((c * acc1) >>> FRAC) - acc2 + longint'(window_q[p]) * 65536;
      if (nxt > ACC_SAT) nxt = ACC_SAT;
      if (nxt < -ACC_SAT) nxt = -ACC_SAT;
      acc2 = acc1;
      acc1 = nxt;
      p = (p + 1) % TAPS;
    end
    a1 = acc1 >>> FRAC;
    a2 = acc2 >>> FRAC;
    cs = (c * a1) >>> FRAC;
    rad = a1 * a1 + a2 * a2 - cs * a2;
    if (rad < 0) rad = 0;
    root = 0;
    for (int b = 30; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= rad) root = trial;
    end
    if (root > longint'(MAG_MAX)) root = longint'(MAG_MAX);
    return root[MAG_W-1:0];
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic typed,
                             input logic [MAG_W-1:0] want);
    logic [MAG_W-1:0] m;
    while (!calm && $urandom_range(99) < 27) @(negedge clk_i);
    if (!calm && $urandom_range(99) < 4) repeat ($urandom_range(1, 200)) @(negedge clk_i);
    sample_bus.valid = 1'b1;
    sample_bus.sample = x;
    do @(posedge clk_i); while (!sample_bus.ready);
    m = slide_and_measure(x);
    expected_mags.push_back(typed ? want : m);
    @(negedge clk_i);
    sample_bus.valid = 1'b0;
  endtask

  task automatic write_coefficient(input logic signed [COEF_W-1:0] value);
    while (expected_mags.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    bin_coefficient_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    coef_q = value;
  endtask

  initial begin
    mag_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        mag_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        mag_bus.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(999) == 0) begin
        mag_bus.ready = 1'b0;
        stall_left = $urandom_range(20, 300);
      end else begin
        mag_bus.ready = ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && mag_bus.valid && mag_bus.ready) begin
      if (expected_mags.size() == 0) begin
        $error("magnitude: no request pending, actual %0d", mag_bus.magnitude);
        failed = 1'b1;
      end else begin
        mag_want = expected_mags.pop_front();
        if (mag_bus.magnitude !== mag_want) begin
          $error("magnitude: expected %0d, actual %0d", mag_want, mag_bus.magnitude);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] x;
    logic signed [COEF_W-1:0]   coef;
    stim_mode_e                 mode;
    int                         run, produced, item_count;
    real                        amp, angle, step;

    sample_bus.valid = 1'b0;
    sample_bus.sample = '0;
    for (int i = 0; i < TAPS; i++) window_q[i] = '0;
    wr_pos_q = 0;
    coef_q = '0;
    item_count = 0;

    directed_rows = '{
      '{ROW_SAMPLE, 0, 1'b1, 22'd0},
      '{ROW_SAMPLE, -32768, 1'b1, 22'd32768},
      '{ROW_SAMPLE, 32767, 1'b0, 22'd0},
      '{ROW_SAMPLE, -1, 1'b0, 22'd0},
      '{ROW_SAMPLE, 1, 1'b0, 22'd0},
      '{ROW_SAMPLE, 21845, 1'b0, 22'd0},
      '{ROW_SAMPLE, -21846, 1'b0, 22'd0},
      '{ROW_COEF, 131072, 1'b0, 22'd0},
      '{ROW_SAMPLE, 32767, 1'b0, 22'd0},
      '{ROW_SAMPLE, 32767, 1'b0, 22'd0},
      '{ROW_SAMPLE, -32768, 1'b0, 22'd0},
      '{ROW_COEF, -131072, 1'b0, 22'd0},
      '{ROW_SAMPLE, 32767, 1'b0, 22'd0},
      '{ROW_SAMPLE, -32768, 1'b0, 22'd0},
      '{ROW_COEF, 262143, 1'b0, 22'd0},
      '{ROW_SAMPLE, 32767, 1'b0, 22'd0},
      '{ROW_SAMPLE, 32767, 1'b0, 22'd0},
      '{ROW_SAMPLE, -32768, 1'b0, 22'd0},
      '{ROW_COEF, -262144, 1'b0, 22'd0},
      '{ROW_SAMPLE, -32768, 1'b0, 22'd0},
      '{ROW_SAMPLE, 32767, 1'b0, 22'd0},
      '{ROW_COEF, 92682, 1'b0, 22'd0},
      '{ROW_SAMPLE, 12345, 1'b0, 22'd0},
      '{ROW_SAMPLE, -12345, 1'b0, 22'd0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_COEF) begin
        write_coefficient(COEF_W'(directed_rows[i].value));
      end else begin
        send_sample(SAMPLE_W'(directed_rows[i].value), directed_rows[i].typed,
                    directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: coef = 130441;
        1: coef = 92682;
        2: coef = -131072;
        3: coef = 0;
        4: coef = 262143;
        5: coef = COEF_W'(int'($urandom_range(0, 262144)) - 131072);
        6: coef = -262144;
        7: coef = COEF_W'($urandom_range(0, 524287));
        8: coef = 131072;
        default: coef = -65536;
      endcase
      write_coefficient(coef);
      produced = 0;
      while (produced < ITEMS_PER_PHASE) begin
        mode = stim_mode_e'($urandom_range(0, 3));
        run = $urandom_range(8, 40);
        amp = real'($urandom_range(1, 32767));
        angle = TWO_PI * real'($urandom_range(0, 1023)) / 1024.0;
        step = TWO_PI * real'($urandom_range(0, 32)) / real'(TAPS);
        for (int k = 0; k < run && produced < ITEMS_PER_PHASE; k++) begin
          case (mode)
            MODE_NOISE: x = SAMPLE_W'($urandom);
            MODE_EXTREME: x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            MODE_TONE: begin
              x = SAMPLE_W'($rtoi(amp * $sin(angle)));
              angle = angle + step;
            end
            default: x = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
          endcase
          calm = (item_count >= CALM_FIRST && item_count < CALM_LAST);
          send_sample(x, 1'b0, '0);
          produced++;
          item_count++;
        end
      end
    end
    calm = 1'b0;

    while (expected_mags.size() != 0) @(posedge clk_i);
    repeat (2 * TAPS + 40) @(posedge clk_i);
    if (!failed) begin
      $display("PASS sliding_goertzel_magnitude");
    end else begin
      $display("FAIL sliding_goertzel_magnitude");
    end
    $finish;
  end

endmodule
